>>> src/tpi_pkg.sv
package tpi_pkg;

    localparam int ACCEL_MS_DEF = 300;
    localparam int AXES_DEF     = 3;
    localparam int MAX_AXES     = 3;

    localparam int TIME_W = 32;
    localparam int DUR_W  = 16;
    localparam int POS_W  = 16;
    localparam int Q_W    = 16;            // quotient bits, lambda < 1 inside the move
    localparam int PROG_W = Q_W + 1;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [PROG_W-1:0] Q16_ONE = PROG_W'(1 << Q_W);
    localparam logic [DUR_W-1:0]  DUR_RST = DUR_W'(1000);

    typedef enum logic [2:0] {
        PH_BEFORE = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DECEL  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [IDX_W-1:0] {
        REG_START = 3'd0,
        REG_DUR   = 3'd1,
        REG_SPOS0 = 3'd2,
        REG_SPOS1 = 3'd3,
        REG_SPOS2 = 3'd4,
        REG_EPOS0 = 3'd5,
        REG_EPOS1 = 3'd6,
        REG_EPOS2 = 3'd7
    } t_reg_idx;

    // per-beat tag carried down the pipe
    typedef struct packed {
        logic   valid;
        t_phase phase;
    } t_meta;

    typedef struct packed {
        logic [PROG_W-1:0]              progress;
        t_phase                         phase;
        logic [MAX_AXES-1:0][POS_W-1:0] target;
    } t_res;

endpackage

>>> src/tpi_div_cell.sv
module tpi_div_cell #(
    parameter int DEN_W = 31
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  tpi_pkg::t_meta       i_meta,
    input  logic [DEN_W-1:0]     i_rem,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [tpi_pkg::Q_W-1:0] i_quo,
    output tpi_pkg::t_meta       o_meta,
    output logic [DEN_W-1:0]     o_rem,
    output logic [tpi_pkg::Q_W-1:0] o_quo
);
    import tpi_pkg::*;

    // one restoring step: shift remainder, try subtract, shift in a quotient bit
    logic [DEN_W:0]   rem2;
    logic [DEN_W:0]   diff;
    logic             fits;
    t_meta            r_meta;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [Q_W-1:0]   r_quo, n_quo;

    always_comb begin
        rem2  = {i_rem, 1'b0};
        diff  = rem2 - {1'b0, i_den};
        fits  = (rem2 >= {1'b0, i_den});
        n_rem = fits ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        n_quo = {i_quo[Q_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_meta = r_meta;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

>>> src/tpi_axis.sv
module tpi_axis (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tpi_pkg::PROG_W-1:0]  i_lambda,
    input  logic [tpi_pkg::POS_W-1:0]   i_spos,
    input  logic [tpi_pkg::POS_W-1:0]   i_epos,
    output logic [tpi_pkg::POS_W-1:0]   o_target
);
    import tpi_pkg::*;

    localparam int PROD_W = PROG_W + 1 + POS_W + 1;

    logic signed [POS_W:0]    span;
    logic signed [PROD_W-1:0] prod;
    logic [POS_W-1:0]         r_step;
    logic [POS_W-1:0]         r_target;

    // floor(lambda*span / 2^16): arithmetic shift, only the low 16 bits survive
    always_comb begin
        span = $signed({i_epos[POS_W-1], i_epos}) - $signed({i_spos[POS_W-1], i_spos});
        prod = $signed({1'b0, i_lambda}) * span;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_step   <= prod[Q_W +: POS_W];
            r_target <= i_spos + r_step;
        end
    end

    assign o_target = r_target;

endmodule

>>> src/trapezoid_profile_interpolator_unit.sv
// Throughput: one beat per cycle while the skid slot is empty; a 16-cell restoring
//   divider chain, one quotient bit per cell, sets the depth, and a one-beat skid
//   buffer decouples output stall.
// Reset (i_rst_n low, synchronous): pipe and output empty, start time 0,
//   duration 1000 ms, all start and end positions 0.
module trapezoid_profile_interpolator_unit #(
    parameter int ACCEL_MS = tpi_pkg::ACCEL_MS_DEF,
    parameter int AXES     = tpi_pkg::AXES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write port
    input  logic                         i_cfg_we,
    input  logic [tpi_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [tpi_pkg::CFG_W-1:0]    i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tpi_pkg::TIME_W-1:0]   i_now_ms,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tpi_pkg::PROG_W-1:0]   o_progress,
    output logic [2:0]                   o_phase,
    output logic [tpi_pkg::POS_W-1:0]    o_target_0,
    output logic [tpi_pkg::POS_W-1:0]    o_target_1,
    output logic [tpi_pkg::POS_W-1:0]    o_target_2
);
    import tpi_pkg::*;

    // width from 2A*65535, an upper bound on the denominator 2A(D-A)
    localparam int DEN_W = $clog2(2 * ACCEL_MS * 65535 + 1);

    localparam logic [DUR_W-1:0] ACC16 = DUR_W'(ACCEL_MS);
    localparam logic [DUR_W-1:0] ACC2  = DUR_W'(2 * ACCEL_MS);
    localparam logic [31:0]      ASQ   = 32'(ACCEL_MS * ACCEL_MS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]              r_start;
    logic [DUR_W-1:0]               r_dur;
    logic [MAX_AXES-1:0][POS_W-1:0] r_spos;
    logic [MAX_AXES-1:0][POS_W-1:0] r_epos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_dur   <= DUR_RST;
            r_spos  <= '0;
            r_epos  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_START: r_start   <= i_cfg_data;
                REG_DUR:   r_dur     <= i_cfg_data[DUR_W-1:0];
                REG_SPOS0: r_spos[0] <= i_cfg_data[POS_W-1:0];
                REG_SPOS1: r_spos[1] <= i_cfg_data[POS_W-1:0];
                REG_SPOS2: r_spos[2] <= i_cfg_data[POS_W-1:0];
                REG_EPOS0: r_epos[0] <= i_cfg_data[POS_W-1:0];
                REG_EPOS1: r_epos[1] <= i_cfg_data[POS_W-1:0];
                REG_EPOS2: r_epos[2] <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // short durations saturate to 2A when used
    logic [DUR_W-1:0] d_eff;
    logic [31:0]      den_full;
    logic [DEN_W-1:0] r_den;

    assign d_eff    = (r_dur < ACC2) ? ACC2 : r_dur;
    assign den_full = 32'(ACC2) * 32'(d_eff - ACC16);

    // user must keep config static while busy (not enforced), so r_den free-runs
    always_ff @(posedge i_clk) begin
        r_den <= den_full[DEN_W-1:0];
    end

    // ------------------------------------------------------------------
    // flow control: the whole pipe moves unless the skid slot is full
    // ------------------------------------------------------------------
    logic adv;
    logic r_skid_v;
    logic r_out_v;

    assign adv        = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // ------------------------------------------------------------------
    // S1: elapsed time, before-start test
    // ------------------------------------------------------------------
    logic [TIME_W:0]   elapsed;
    logic              r1_v;
    logic              r1_before;
    logic [TIME_W-1:0] r1_u;

    assign elapsed = {1'b0, i_now_ms} - {1'b0, r_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_before <= elapsed[TIME_W] || (elapsed[TIME_W-1:0] == '0);
            r1_u      <= elapsed[TIME_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // S2: phase and multiplier operands
    //   accel  N = u^2
    //   cruise N = 2A*u - A^2
    //   decel  N = den - (D-u)^2
    // ------------------------------------------------------------------
    t_phase           ph2;
    logic [DUR_W-1:0] u16;
    logic [DUR_W-1:0] v16;
    logic [DUR_W-1:0] mul_a, mul_b;
    t_meta            r2_meta;
    logic [DUR_W-1:0] r2_a, r2_b;

    assign u16 = r1_u[DUR_W-1:0];   // below D whenever it matters
    assign v16 = d_eff - u16;

    always_comb begin
        if (r1_before) begin
            ph2 = PH_BEFORE;
        end else if (r1_u >= TIME_W'(d_eff)) begin
            ph2 = PH_DONE;
        end else if (u16 < ACC16) begin
            ph2 = PH_ACCEL;
        end else if (u16 <= d_eff - ACC16) begin
            ph2 = PH_CRUISE;
        end else begin
            ph2 = PH_DECEL;
        end
        case (ph2)
            PH_CRUISE: begin
                mul_a = u16;
                mul_b = ACC2;
            end
            PH_DECEL: begin
                mul_a = v16;
                mul_b = v16;
            end
            default: begin
                mul_a = u16;
                mul_b = u16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_meta <= '0;
        end else if (adv) begin
            r2_meta <= '{valid: r1_v, phase: ph2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_a <= mul_a;
            r2_b <= mul_b;
        end
    end

    // ------------------------------------------------------------------
    // S3: product
    // ------------------------------------------------------------------
    t_meta       r3_meta;
    logic [31:0] r3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_meta <= '0;
        end else if (adv) begin
            r3_meta <= r2_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_prod <= 32'(r2_a) * 32'(r2_b);
        end
    end

    // ------------------------------------------------------------------
    // S4: numerator, always below den inside the move
    // ------------------------------------------------------------------
    logic [31:0]      n32;
    t_meta            r4_meta;
    logic [DEN_W-1:0] r4_n;

    always_comb begin
        case (r3_meta.phase)
            PH_ACCEL:  n32 = r3_prod;
            PH_CRUISE: n32 = r3_prod - ASQ;
            PH_DECEL:  n32 = 32'(r_den) - r3_prod;
            default:   n32 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_meta <= '0;
        end else if (adv) begin
            r4_meta <= r3_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_n <= n32[DEN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // divider chain: lambda = floor(N * 2^16 / den), one bit per cell
    // ------------------------------------------------------------------
    t_meta            c_meta [Q_W+1];
    logic [DEN_W-1:0] c_rem  [Q_W+1];
    logic [Q_W-1:0]   c_quo  [Q_W+1];

    assign c_meta[0] = r4_meta;
    assign c_rem[0]  = r4_n;
    assign c_quo[0]  = '0;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        tpi_div_cell #(
            .DEN_W (DEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_meta  (c_meta[k]),
            .i_rem   (c_rem[k]),
            .i_den   (r_den),
            .i_quo   (c_quo[k]),
            .o_meta  (c_meta[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_quo   (c_quo[k+1])
        );
    end

    logic [PROG_W-1:0] lambda;

    always_comb begin
        case (c_meta[Q_W].phase)
            PH_BEFORE: lambda = '0;
            PH_DONE:   lambda = Q16_ONE;
            default:   lambda = {1'b0, c_quo[Q_W]};
        endcase
    end

    // ------------------------------------------------------------------
    // P1/P2: per-axis interpolation, two stages
    // ------------------------------------------------------------------
    t_meta             r5_meta, r6_meta;
    logic [PROG_W-1:0] r5_lambda, r6_lambda;
    logic [MAX_AXES-1:0][POS_W-1:0] tgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_meta <= '0;
            r6_meta <= '0;
        end else if (adv) begin
            r5_meta <= c_meta[Q_W];
            r6_meta <= r5_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_lambda <= lambda;
            r6_lambda <= r5_lambda;
        end
    end

    for (genvar g = 0; g < MAX_AXES; g++) begin : g_axis
        if (g < AXES) begin : g_on
            tpi_axis u_axis (
                .i_clk    (i_clk),
                .i_en     (adv),
                .i_lambda (lambda),
                .i_spos   (r_spos[g]),
                .i_epos   (r_epos[g]),
                .o_target (tgt[g])
            );
        end else begin : g_off
            assign tgt[g] = '0;
        end
    end

    // ------------------------------------------------------------------
    // output register with one-beat skid
    // ------------------------------------------------------------------
    t_res pipe_res;
    t_res r_out, r_skid;
    logic out_free;

    assign pipe_res = '{progress: r6_lambda, phase: r6_meta.phase, target: tgt};
    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r6_meta.valid;
            end
        end else if (r6_meta.valid && adv) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : pipe_res;
        end else if (adv) begin
            r_skid <= pipe_res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_progress  = r_out.progress;
    assign o_phase     = r_out.phase;
    assign o_target_0  = r_out.target[0];
    assign o_target_1  = r_out.target[1];
    assign o_target_2  = r_out.target[2];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_progress <= Q16_ONE)
        else $error("progress above one");

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_phase == PH_DONE) |-> o_progress == Q16_ONE)
        else $error("done beat without full progress");

    a_before_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_phase == PH_BEFORE) |-> o_progress == '0)
        else $error("before-start beat with nonzero progress");

    a_skid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a beat while output is empty");

endmodule

>>> tb/tb_trapezoid_profile_interpolator_unit.sv
`timescale 1ns / 100ps

module tb_trapezoid_profile_interpolator_unit;
    import tpi_pkg::*;

    // Scoreboard: holds a shadow copy of the move registers and the queue of
    // profile samples still owed by the pipe, oldest first.
    class move_scoreboard;
        logic [TIME_W-1:0] start_ms;
        logic [DUR_W-1:0]  dur_ms;
        logic [POS_W-1:0]  spos [MAX_AXES];
        logic [POS_W-1:0]  epos [MAX_AXES];
        t_res              pending_profiles[$];
        int                fails;

        function new();
            start_ms = '0;
            dur_ms   = DUR_RST;
            foreach (spos[i]) begin
                spos[i] = '0;
                epos[i] = '0;
            end
            fails = 0;
        endfunction

        // 16-bit registers keep only the low half of the write data
        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_START: start_ms = data;
                REG_DUR:   dur_ms   = data[DUR_W-1:0];
                REG_SPOS0: spos[0]  = data[POS_W-1:0];
                REG_SPOS1: spos[1]  = data[POS_W-1:0];
                REG_SPOS2: spos[2]  = data[POS_W-1:0];
                REG_EPOS0: epos[0]  = data[POS_W-1:0];
                REG_EPOS1: epos[1]  = data[POS_W-1:0];
                REG_EPOS2: epos[2]  = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // Progress, phase and axis targets of the trapezoidal move at time now.
        function t_res trapezoid_point(logic [TIME_W-1:0] now);
            longint unsigned acc, dur, u, n, lam;
            longint          s, e, p;
            t_res            r;
            r   = '0;
            acc = ACCEL_MS_DEF;
            dur = dur_ms;
            if (dur < 2 * acc) dur = 2 * acc;    // short move: ramps meet in the middle
            if (now <= start_ms) begin
                lam     = 0;
                r.phase = PH_BEFORE;
            end else begin
                u = now - start_ms;
                if (u >= dur) begin
                    lam     = Q16_ONE;
                    r.phase = PH_DONE;
                end else begin
                    if (u < acc) begin
                        n       = u * u;
                        r.phase = PH_ACCEL;
                    end else if (u <= dur - acc) begin
                        n       = acc * acc + 2 * acc * (u - acc);
                        r.phase = PH_CRUISE;
                    end else begin
                        n       = (u + acc - dur) * (dur + acc - u) + acc * acc
                                  + 2 * acc * (dur - 2 * acc);
                        r.phase = PH_DECEL;
                    end
                    lam = (n << 16) / (2 * acc * (dur - acc));
                    if (lam > Q16_ONE) lam = Q16_ONE;
                end
            end
            r.progress = lam[PROG_W-1:0];
            for (int i = 0; i < MAX_AXES; i++) begin
                if (i < AXES_DEF) begin
                    s = $signed(spos[i]);
                    e = $signed(epos[i]);
                    // arithmetic shift of a signed product floors toward -inf
                    p = s + ((longint'(lam) * (e - s)) >>> Q_W);
                    r.target[i] = p[POS_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_input(logic [TIME_W-1:0] now);
            pending_profiles.push_back(trapezoid_point(now));
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_profiles.size() == 0) begin
                $error("result beat with no sample pending");
                fails++;
                return;
            end
            want = pending_profiles.pop_front();
            if (got.progress !== want.progress) begin
                $error("progress: expected %0d, got %0d", want.progress, got.progress);
                fails++;
            end
            if (got.phase !== want.phase) begin
                $error("phase: expected %0d, got %0d", want.phase, got.phase);
                fails++;
            end
            for (int i = 0; i < MAX_AXES; i++) begin
                if (got.target[i] !== want.target[i]) begin
                    $error("target_%0d: expected %0d, got %0d", i,
                           $signed(want.target[i]), $signed(got.target[i]));
                    fails++;
                end
            end
        endfunction
    endclass

    // settle time after the pipe has drained, before touching registers
    localparam int SETTLE_CYCLES = 30;
    localparam int RAND_PHASES   = 6;
    localparam int BEATS_PER_PH  = 75;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [TIME_W-1:0]     i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PROG_W-1:0]     o_progress;
    logic [2:0]            o_phase;
    logic [POS_W-1:0]      o_target_0;
    logic [POS_W-1:0]      o_target_1;
    logic [POS_W-1:0]      o_target_2;

    move_scoreboard sb;
    bit             tx_burst;   // sender never idles while set
    bit             rx_burst;   // receiver never stalls while set

    trapezoid_profile_interpolator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_progress  (o_progress),
        .o_phase     (o_phase),
        .o_target_0  (o_target_0),
        .o_target_1  (o_target_1),
        .o_target_2  (o_target_2)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output monitor: every accepted result beat goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_res'({o_progress, o_phase, o_target_2, o_target_1, o_target_0}));
    end

    // Receiver: after each taken beat, may stall for a randomly drawn hold unless
    // in a burst stretch. Stall moves only on falling edges.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                hold = rx_burst ? 0 : $urandom_range(0, 16);
                @(negedge i_clk);
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Enter and leave at a falling edge. Valid stays high across back-to-back
    // beats; the payload is held until the beat is taken.
    task automatic send_time(input logic [TIME_W-1:0] now);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms   <= now;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(now);
        @(negedge i_clk);
    endtask

    // Sender holds off until the pipe has delivered everything, then settles.
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (sb.pending_profiles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write enable is left high between back-to-back writes; caller drops it
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Program a whole move. Upper bits of 16-bit writes carry junk on purpose.
    task automatic program_move(input logic [TIME_W-1:0] st, input logic [DUR_W-1:0] dur,
                                input logic [MAX_AXES-1:0][POS_W-1:0] sp,
                                input logic [MAX_AXES-1:0][POS_W-1:0] ep);
        write_reg(REG_START, st);
        write_reg(REG_DUR,   {16'($urandom()), dur});
        write_reg(REG_SPOS0, {16'($urandom()), sp[0]});
        write_reg(REG_SPOS1, {16'($urandom()), sp[1]});
        write_reg(REG_SPOS2, {16'($urandom()), sp[2]});
        write_reg(REG_EPOS0, {16'($urandom()), ep[0]});
        write_reg(REG_EPOS1, {16'($urandom()), ep[1]});
        write_reg(REG_EPOS2, {16'($urandom()), ep[2]});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_pos();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return POS_W'($urandom());
        endcase
    endfunction

    // Mostly times inside the move, with edges of each ramp and the end,
    // some before the start and some fully random 32-bit stamps.
    function automatic logic [TIME_W-1:0] pick_now(logic [TIME_W-1:0] st, int deff);
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return st - $urandom_range(0, 3);
            2:       return st + deff - 2 + $urandom_range(0, 4);
            3:       return st + ACCEL_MS_DEF - 1 + $urandom_range(0, 2);
            4:       return st + deff - ACCEL_MS_DEF - 1 + $urandom_range(0, 2);
            default: return st + $urandom_range(0, deff + 10);
        endcase
    endfunction

    initial begin
        logic [TIME_W-1:0]              st;
        logic [DUR_W-1:0]               dur;
        logic [MAX_AXES-1:0][POS_W-1:0] sp, ep;
        int                             deff;

        sb          = new();
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_now_ms    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset move: start 0, 1000 ms, all positions 0. Time at start,
        // both ramp edges, cruise end, the end itself and the top of the range.
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'd299);
        send_time(32'd300);
        send_time(32'd700);
        send_time(32'd701);
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'hFFFF_FFFF);
        drain_pipe();

        // Duration 0 saturates to 2A, cruise at one point; axes 0 and 1 start and end at
        // the extremes so the span is the full signed range in both directions.
        program_move(32'd1000, 16'd0, {16'h1234, 16'h7FFF, 16'h8000},
                     {16'hEDCB, 16'h8000, 16'h7FFF});
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'd1001);
        send_time(32'd1299);
        send_time(32'd1300);
        send_time(32'd1301);
        send_time(32'd1599);
        send_time(32'd1600);
        send_time(32'd0);
        drain_pipe();

        // Latest possible start with the longest duration: nothing ever moves.
        program_move(32'hFFFF_FFFF, 16'hFFFF, {16'h0001, 16'h8000, 16'h7FFF},
                     {16'hFFFF, 16'h0000, 16'h8000});
        send_time(32'hFFFF_FFFE);
        send_time(32'hFFFF_FFFF);
        send_time(32'd0);
        drain_pipe();

        // Random moves; the first one runs flat out on both sides.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       dur = DUR_W'($urandom_range(0, 599));
                1:       dur = 16'd600;
                2:       dur = DUR_W'($urandom_range(601, 2000));
                3:       dur = 16'hFFFF;
                default: dur = DUR_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       st = '0;
                1:       st = 32'hFFFF_FFFF - $urandom_range(0, 70000);
                default: st = $urandom();
            endcase
            for (int i = 0; i < MAX_AXES; i++) begin
                sp[i] = pick_pos();
                ep[i] = pick_pos();
            end
            deff = (int'(dur) < 2 * ACCEL_MS_DEF) ? 2 * ACCEL_MS_DEF : int'(dur);
            program_move(st, dur, sp, ep);
            tx_burst = (ph == 0) || ($urandom_range(0, 3) == 0);
            rx_burst = (ph == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < BEATS_PER_PH; k++)
                send_time(pick_now(st, deff));
            drain_pipe();
        end

        if (sb.fails == 0)
            $display("tb_trapezoid_profile_interpolator_unit: clean");
        else
            $display("tb_trapezoid_profile_interpolator_unit: errors");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run of about 500 beats.
    initial begin
        #1_000_000;
        $display("tb_trapezoid_profile_interpolator_unit: errors");
        $finish;
    end

endmodule
